// File: src/pwmss_pkg.sv
// shared types, constants and helpers for the pwm alignment site scorer
// no dependencies; imported by the divider and the top level
`default_nettype none

package pwmss_pkg;

  // default sizes for the top-level parameters
  localparam int MAX_WIDTH_DEF     = 32;
  localparam int MAX_SEQUENCES_DEF = 256;
  localparam int WEIGHT_BITS_DEF   = 16;

  // fixed field widths
  localparam int CUTOFF_W = 24;
  localparam int MWIDTH_W = 6;
  localparam int COLUMN_W = 5;
  localparam int SLOT_W   = 2;
  localparam int INW_W    = 16;
  localparam int CHAR_W   = 8;
  localparam int RESULT_W = 21;
  localparam int SEQOUT_W = 9;
  localparam int TOTAL_W  = 30;

  // apb port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // saturation bounds of the mean result, as magnitudes
  localparam logic [TOTAL_W-1:0] RES_POS_MAG = TOTAL_W'((1 << (RESULT_W - 1)) - 1);
  localparam logic [TOTAL_W-1:0] RES_NEG_MAG = TOTAL_W'(1 << (RESULT_W - 1));

  // register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_CUTOFF = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  // item actions and scoring modes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_BASE   = 1'b1;
  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_MEAN  = 1'b1;

  // base codes
  localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

  localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_C = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_G = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_T = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } base_t;

  // map a raw character to a base slot
  function automatic base_t base_lookup(input logic [CHAR_W-1:0] ch);
    base_t b;
    b.hit  = 1'b1;
    b.slot = SLOT_A;
    case (ch)
      CH_A_UP, CH_A_LO: b.slot = SLOT_A;
      CH_C_UP, CH_C_LO: b.slot = SLOT_C;
      CH_G_UP, CH_G_LO: b.slot = SLOT_G;
      CH_T_UP, CH_T_LO: b.slot = SLOT_T;
      default:          b.hit  = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/pwm_alignment_site_scorer_top.sv
// pwm alignment site scorer: a weight table in memory scores streamed alignment characters
// usage: channels, timing and reset behavior are described below
// depends on pwmss_pkg, pwmss_wtab and pwmss_div
//
// Input channel (in_valid/in_ready) carries one item per beat. A load item writes one
// weight into the table (column, letter_slot, weight). A character item reads the table
// entry for the current column and base, which the table registers, and updates the
// running score in the cycle after; no new item is taken until then. A character marked
// last_in_set then passes through S_FIN and, in mean mode with sequences counted, S_DIV,
// where a one-bit-per-cycle divider forms total / sequences, before S_RES holds the result.
// The result beat (out_valid/out_ready) carries set_result, sequences_in_set and
// empty_set, and sits in an output register: the next item is accepted while it waits.
// If the receiver stalls and a second result is ready, the block holds that result and
// takes no input until the output register frees up.
// Registers are written over the APB port (0x0 score_cutoff, 0x4 motif_width, 0x8 score_mode);
// the user writes them only while the block is idle, which the block does not enforce; pready is always high.
// Synchronous reset clears the per-set state and the registers (width 32, count mode,
// cutoff 0). The weight table is not cleared and must be loaded before use.
`default_nettype none

module pwm_alignment_site_scorer_top
  import pwmss_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_SEQUENCES = MAX_SEQUENCES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // apb configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic        [PADDR_W-1:0]  paddr,
  input  wire logic        [PDATA_W-1:0]  pwdata,
  output logic             [PDATA_W-1:0]  prdata,
  output logic                            pready,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic        [COLUMN_W-1:0] in_column,
  input  wire logic        [SLOT_W-1:0]   in_letter_slot,
  input  wire logic signed [INW_W-1:0]    in_weight,
  input  wire logic        [CHAR_W-1:0]   in_base_char,
  input  wire logic                       in_last_in_sequence,
  input  wire logic                       in_last_in_set,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [RESULT_W-1:0] out_set_result,
  output logic             [SEQOUT_W-1:0] out_sequences_in_set,
  output logic                            out_empty_set
);

  localparam int ADDR_W  = $clog2(MAX_WIDTH * 4);
  localparam int COL_W   = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W   = $clog2(MAX_SEQUENCES + 1);
  localparam int SCORE_W = WEIGHT_BITS + COL_W;
  localparam int CMP_W   = (SCORE_W > CUTOFF_W) ? SCORE_W : CUTOFF_W;
  localparam int SUM_W   = ((SCORE_W > TOTAL_W) ? SCORE_W : TOTAL_W) + 1;
  localparam longint WMAX = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCORE = 5'b00010,
    S_FIN   = 5'b00100,
    S_DIV   = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [CUTOFF_W-1:0] cutoff_r;
  logic        [MWIDTH_W-1:0] mwidth_r;
  logic                       mode_r;
  logic                       cfg_wr;

  // per-set and per-sequence state
  logic        [COL_W-1:0]   colpos_r, colpos_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic        [CNT_W-1:0]   count_r, count_nxt;
  logic        [CNT_W-1:0]   match_r, match_nxt;

  // captured item
  logic hit_r, end_seq_r, end_set_r;

  // pending result
  logic signed [RESULT_W-1:0] res_r, res_nxt;
  logic                       empty_r, empty_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [RESULT_W-1:0] out_res_r;
  logic        [SEQOUT_W-1:0] out_seq_r;
  logic                       out_empty_r;
  logic                       out_load;

  // table and divider connections
  logic                       accept;
  base_t                      base;
  logic [COL_W-1:0]           act_width;
  logic                       col_hit;
  logic                       wt_we;
  logic [ADDR_W-1:0]          wt_waddr;
  logic [WEIGHT_BITS-1:0]     wt_wdata;
  logic                       wt_re;
  logic [ADDR_W-1:0]          wt_raddr;
  logic [WEIGHT_BITS-1:0]     wt_rdata;
  logic                       div_start;
  logic                       div_done;
  logic [TOTAL_W-1:0]         div_quo;
  logic [TOTAL_W-1:0]         total_mag;
  logic                       neg_r;
  longint                     wext;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      mwidth_r <= MWIDTH_W'(32);
      mode_r   <= MODE_COUNT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CUTOFF: cutoff_r <= pwdata[CUTOFF_W-1:0];
        REG_WIDTH:  mwidth_r <= pwdata[MWIDTH_W-1:0];
        REG_MODE:   mode_r   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CUTOFF: prdata = {{(PDATA_W-CUTOFF_W){cutoff_r[CUTOFF_W-1]}}, cutoff_r};
      REG_WIDTH:  prdata = {{(PDATA_W-MWIDTH_W){1'b0}}, mwidth_r};
      REG_MODE:   prdata = {{(PDATA_W-1){1'b0}}, mode_r};
      default:    prdata = '0;
    endcase
  end

  // width in use: zero acts as one, clipped to the table size
  always_comb begin
    if (mwidth_r == '0) begin
      act_width = COL_W'(1);
    end else if (int'(mwidth_r) > MAX_WIDTH) begin
      act_width = COL_W'(MAX_WIDTH);
    end else begin
      act_width = COL_W'(mwidth_r);
    end
  end

  // intake: loads write the table, characters start a read
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign base     = base_lookup(in_base_char);
  assign col_hit  = base.hit && (colpos_r < act_width);

  always_comb begin
    wext = longint'(in_weight);
    if (wext > WMAX) begin
      wt_wdata = WEIGHT_BITS'(WMAX);
    end else if (wext < WMIN) begin
      wt_wdata = WEIGHT_BITS'(WMIN);
    end else begin
      wt_wdata = WEIGHT_BITS'(wext);
    end
  end

  assign wt_we    = accept && (in_action == ACT_LOAD) && (int'(in_column) < MAX_WIDTH);
  assign wt_waddr = ADDR_W'({in_column, in_letter_slot});
  assign wt_re    = accept && (in_action == ACT_BASE) && col_hit;
  assign wt_raddr = ADDR_W'({colpos_r, base.slot});

  pwmss_wtab #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wtab (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .re    (wt_re),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r     <= col_hit;
      end_seq_r <= in_last_in_sequence;
      end_set_r <= in_last_in_set;
    end
  end

  // mean divider on the magnitude of the set total
  assign total_mag = total_r[TOTAL_W-1] ? TOTAL_W'(-total_r) : TOTAL_W'(total_r);
  assign div_start = (state_r == S_FIN) && (mode_r == MODE_MEAN) && (count_r != '0);

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= total_r[TOTAL_W-1];
    end
  end

  pwmss_div #(
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_mag),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // score update, set end handling and result hand-off
  logic signed [SCORE_W-1:0] score_add;
  logic        [COL_W-1:0]   colpos_add;
  logic signed [CMP_W-1:0]   score_cmp;
  logic signed [CMP_W-1:0]   cutoff_cmp;
  logic signed [SUM_W-1:0]   sum;
  logic                      sum_ovf;

  assign score_add  = hit_r
                    ? score_r + {{(SCORE_W-WEIGHT_BITS){wt_rdata[WEIGHT_BITS-1]}}, wt_rdata}
                    : score_r;
  assign colpos_add = colpos_r + COL_W'(hit_r);
  assign score_cmp  = CMP_W'(score_add);
  assign cutoff_cmp = CMP_W'(cutoff_r);
  assign sum        = SUM_W'(total_r) + SUM_W'(score_add);
  assign sum_ovf    = !((&sum[SUM_W-1:TOTAL_W-1]) || !(|sum[SUM_W-1:TOTAL_W-1]));
  assign out_load   = (state_r == S_RES) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    colpos_nxt = colpos_r;
    score_nxt  = score_r;
    total_nxt  = total_r;
    count_nxt  = count_r;
    match_nxt  = match_r;
    res_nxt    = res_r;
    empty_nxt  = empty_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ACT_BASE)) begin
          state_nxt = S_SCORE;
        end
      end
      S_SCORE: begin
        if (end_seq_r) begin
          if (count_r < CNT_W'(MAX_SEQUENCES)) begin
            count_nxt = count_r + 1'b1;
            if (sum_ovf) begin
              total_nxt = sum[SUM_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                       : {1'b0, {(TOTAL_W-1){1'b1}}};
            end else begin
              total_nxt = sum[TOTAL_W-1:0];
            end
            if ((colpos_add == act_width) && (score_cmp > cutoff_cmp)) begin
              match_nxt = match_r + 1'b1;
            end
          end
          colpos_nxt = '0;
          score_nxt  = '0;
        end else begin
          colpos_nxt = colpos_add;
          score_nxt  = score_add;
        end
        state_nxt = end_set_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        empty_nxt = (count_r == '0);
        res_nxt   = (count_r == '0) ? '0 : RESULT_W'(match_r);
        state_nxt = div_start ? S_DIV : S_RES;
      end
      S_DIV: begin
        if (div_done) begin
          if (!neg_r) begin
            res_nxt = (div_quo > RES_POS_MAG) ? RESULT_W'(RES_POS_MAG)
                                              : RESULT_W'(div_quo);
          end else begin
            res_nxt = (div_quo > RES_NEG_MAG) ? RESULT_W'(-RES_NEG_MAG)
                                              : RESULT_W'(-div_quo);
          end
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_load) begin
          colpos_nxt = '0;
          score_nxt  = '0;
          total_nxt  = '0;
          count_nxt  = '0;
          match_nxt  = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      colpos_r <= '0;
      score_r  <= '0;
      total_r  <= '0;
      count_r  <= '0;
      match_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      colpos_r <= colpos_nxt;
      score_r  <= score_nxt;
      total_r  <= total_nxt;
      count_r  <= count_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    empty_r <= empty_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r   <= res_r;
      out_seq_r   <= SEQOUT_W'(count_r);
      out_empty_r <= empty_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_set_result       = out_res_r;
  assign out_sequences_in_set = out_seq_r;
  assign out_empty_set        = out_empty_r;

endmodule

`default_nettype wire

// File: src/pwmss_wtab.sv
// weight table: synchronous memory, one write port and one registered read port
// no package dependency; instantiated by the top level
`default_nettype none

module pwmss_wtab #(
  parameter int MAX_WIDTH   = 32,
  parameter int WEIGHT_BITS = 16,
  localparam int DEPTH      = MAX_WIDTH * 4,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_W-1:0]      waddr,
  input  wire logic [WEIGHT_BITS-1:0] wdata,
  input  wire logic                   re,
  input  wire logic [ADDR_W-1:0]      raddr,
  output logic      [WEIGHT_BITS-1:0] rdata
);

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/pwmss_div.sv
// iterative unsigned divider for the mean score, one quotient bit per cycle
// depends on pwmss_pkg for the dividend width
`default_nettype none

module pwmss_div
  import pwmss_pkg::*;
#(
  parameter int DSR_W = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [TOTAL_W-1:0] dividend,
  input  wire logic [DSR_W-1:0]   divisor,
  output logic                    done,
  output logic      [TOTAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TOTAL_W + 1);

  logic [TOTAL_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0]   rem_r, rem_nxt;
  logic [DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [DSR_W:0]     shifted;
  logic [DSR_W:0]     diff;

  // one restoring step
  always_comb begin
    shifted  = {rem_r, quo_r[TOTAL_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CNT_W'(TOTAL_W);
    end else if (cnt_r != '0) begin
      if (!diff[DSR_W]) begin
        rem_nxt = diff[DSR_W-1:0];
        quo_nxt = {quo_r[TOTAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DSR_W-1:0];
        quo_nxt = {quo_r[TOTAL_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // control resets, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for pwm_alignment_site_scorer_top: directed rows, then random sets
// depends on pwmss_pkg and the scorer rtl; predicts each set result in its own scoring model

module testbench;
  import pwmss_pkg::*;

  localparam int RANDOM_ITEMS  = 400;
  localparam int MIN_RESULTS   = 60;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int OVERFLOW_SEQS = MAX_SEQUENCES_DEF + 4;
  localparam longint TOTAL_HI  = 64'sd536870911;
  localparam longint TOTAL_LO  = -64'sd536870912;
  localparam longint RESULT_HI = 64'sd1048575;
  localparam longint RESULT_LO = -64'sd1048576;

  typedef struct packed {
    logic                       action;
    logic        [COLUMN_W-1:0] column;
    logic        [SLOT_W-1:0]   slot;
    logic signed [INW_W-1:0]    weight;
    logic        [CHAR_W-1:0]   ch;
    logic                       eseq;
    logic                       eset;
  } scorer_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] set_result;
    logic        [SEQOUT_W-1:0] sequences_in_set;
    logic                       empty_set;
  } set_summary_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    reg_idx_t     reg_sel;
    logic [31:0]  reg_val;
    scorer_item_t item;
    logic         typed;
    set_summary_t summary;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       psel, penable, pwrite;
  logic        [PADDR_W-1:0]  paddr;
  logic        [PDATA_W-1:0]  pwdata;
  logic        [PDATA_W-1:0]  prdata;
  logic                       pready;
  logic                       in_valid, in_ready;
  logic                       in_action;
  logic        [COLUMN_W-1:0] in_column;
  logic        [SLOT_W-1:0]   in_letter_slot;
  logic signed [INW_W-1:0]    in_weight;
  logic        [CHAR_W-1:0]   in_base_char;
  logic                       in_last_in_sequence, in_last_in_set;
  logic                       out_valid, out_ready;
  logic signed [RESULT_W-1:0] out_set_result;
  logic        [SEQOUT_W-1:0] out_sequences_in_set;
  logic                       out_empty_set;

  // typed expectation travels with the beat, like the payload
  logic         row_typed;
  set_summary_t row_summary;

  // scoring model state and register copies
  logic signed [INW_W-1:0] pwm_weights [4*MAX_WIDTH_DEF];
  int          col_pos, seqs_closed, seqs_matched;
  longint      seq_score, set_sum, cut_q88;
  logic [5:0]  width_field;
  logic        mode_field;

  set_summary_t set_summaries_due[$];
  stim_row_t    directed_rows[$];
  int           items_sent, results_seen, failures, cycles;
  bit           long_hold_done;

  pwm_alignment_site_scorer_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_column            (in_column),
    .in_letter_slot       (in_letter_slot),
    .in_weight            (in_weight),
    .in_base_char         (in_base_char),
    .in_last_in_sequence  (in_last_in_sequence),
    .in_last_in_set       (in_last_in_set),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_set_result       (out_set_result),
    .out_sequences_in_set (out_sequences_in_set),
    .out_empty_set        (out_empty_set)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               set_summaries_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int active_width();
    if (width_field == 6'd0) return 1;
    if (width_field > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_field);
  endfunction

  // advance the scoring model by one beat; returns 1 when the beat closes a set
  function automatic bit score_item(input scorer_item_t it, output set_summary_t s);
    bit          hit;
    logic [1:0]  slot;
    int          aw;
    longint      res;
    s = '0;
    if (it.action == ACT_LOAD) begin
      pwm_weights[int'(it.column) * 4 + int'(it.slot)] = it.weight;
      return 1'b0;
    end
    hit = 1'b1;
    slot = SLOT_A;
    case (it.ch)
      CH_A_UP, CH_A_LO: slot = SLOT_A;
      CH_C_UP, CH_C_LO: slot = SLOT_C;
      CH_G_UP, CH_G_LO: slot = SLOT_G;
      CH_T_UP, CH_T_LO: slot = SLOT_T;
      default:          hit = 1'b0;
    endcase
    aw = active_width();
    if (hit && col_pos < aw) begin
      seq_score += pwm_weights[col_pos * 4 + int'(slot)];
      col_pos++;
    end
    if (it.eseq) begin
      // sequences past the limit are dropped
      if (seqs_closed < MAX_SEQUENCES_DEF) begin
        seqs_closed++;
        set_sum += seq_score;
        if (set_sum > TOTAL_HI) set_sum = TOTAL_HI;
        if (set_sum < TOTAL_LO) set_sum = TOTAL_LO;
        if (col_pos == aw && seq_score > cut_q88) seqs_matched++;
      end
      col_pos = 0;
      seq_score = 0;
    end
    if (!it.eset) return 1'b0;
    if (seqs_closed == 0) begin
      s.empty_set = 1'b1;
    end else begin
      // mean truncates toward zero
      res = (mode_field == MODE_COUNT) ? longint'(seqs_matched) : set_sum / seqs_closed;
      if (res > RESULT_HI) res = RESULT_HI;
      if (res < RESULT_LO) res = RESULT_LO;
      s.set_result = res[RESULT_W-1:0];
      s.sequences_in_set = seqs_closed[SEQOUT_W-1:0];
    end
    col_pos = 0;
    seq_score = 0;
    set_sum = 0;
    seqs_closed = 0;
    seqs_matched = 0;
    return 1'b1;
  endfunction

  // result check first, then prediction for the accepted input beat
  always @(posedge clk) begin
    scorer_item_t it;
    set_summary_t want, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{out_set_result, out_sequences_in_set, out_empty_set};
        if (set_summaries_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result beat: result %0d seqs %0d empty %0b",
                     got.set_result, got.sequences_in_set, got.empty_set);
        end else begin
          want = set_summaries_due.pop_front();
          if (got.set_result !== want.set_result ||
              got.sequences_in_set !== want.sequences_in_set ||
              got.empty_set !== want.empty_set) begin
            failures++;
            if (failures <= 10)
              $display("result %0d mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                       results_seen, want.set_result, want.sequences_in_set,
                       want.empty_set, got.set_result, got.sequences_in_set,
                       got.empty_set);
          end
        end
      end
      if (in_valid && in_ready) begin
        it = '{in_action, in_column, in_letter_slot, in_weight, in_base_char,
               in_last_in_sequence, in_last_in_set};
        if (score_item(it, want))
          set_summaries_due.push_back(row_typed ? row_summary : want);
      end
    end
  end

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 12) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (results_seen >= 25 && results_seen < 40) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  function automatic logic signed [INW_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return INW_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] bases [8] = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                                     CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO};
    if ($urandom_range(0, 99) < 85) return bases[$urandom_range(0, 7)];
    return CHAR_W'($urandom);
  endfunction

  function automatic scorer_item_t random_item(input logic action);
    scorer_item_t it;
    it = '{action, COLUMN_W'($urandom), SLOT_W'($urandom), pick_weight(), pick_char(),
           1'($urandom), 1'($urandom)};
    return it;
  endfunction

  function automatic stim_row_t char_row(input logic [7:0] ch, input logic eseq,
                                         input logic eset);
    stim_row_t r;
    r = '{ROW_ITEM, REG_CUTOFF, 32'd0, '0, 1'b0, '0};
    r.item = '{ACT_BASE, 5'd0, SLOT_A, 16'sd0, ch, eseq, eset};
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] ch, input logic eseq,
                                          input logic eset, input int res,
                                          input int seqs, input logic empty);
    stim_row_t r;
    r = char_row(ch, eseq, eset);
    r.typed = 1'b1;
    r.summary = '{RESULT_W'(res), SEQOUT_W'(seqs), empty};
    return r;
  endfunction

  function automatic stim_row_t load_row(input logic [4:0] col, input logic [1:0] slot,
                                         input logic signed [15:0] w, input logic flags);
    stim_row_t r;
    r = '{ROW_ITEM, REG_CUTOFF, 32'd0, '0, 1'b0, '0};
    r.item = '{ACT_LOAD, col, slot, w, 8'h00, flags, flags};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input reg_idx_t r_sel, input logic [31:0] v);
    stim_row_t r;
    r = '{ROW_CFG, r_sel, v, '0, 1'b0, '0};
    return r;
  endfunction

  // one input beat, with random gaps ahead of it outside the steady stretch
  task automatic send_item(input scorer_item_t it, input logic typed,
                           input set_summary_t fixed);
    while (!(items_sent >= 200 && items_sent < 280) && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= it.action;
    in_column           <= it.column;
    in_letter_slot      <= it.slot;
    in_weight           <= it.weight;
    in_base_char        <= it.ch;
    in_last_in_sequence <= it.eseq;
    in_last_in_set      <= it.eset;
    row_typed           <= typed;
    row_summary         <= fixed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending until every due result is in and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (set_summaries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access; model copy follows the register
  task automatic write_reg(input reg_idx_t r_sel, input logic [31:0] v);
    case (r_sel)
      REG_CUTOFF: cut_q88 = longint'($signed(v[CUTOFF_W-1:0]));
      REG_WIDTH:  width_field = v[MWIDTH_W-1:0];
      REG_MODE:   mode_field = v[0];
      default:    ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r_sel, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one set of sequences with random content; some end the set on an open sequence
  task automatic send_set();
    int           n_seq, len, aw;
    bit           broken, last;
    scorer_item_t it;
    aw = active_width();
    n_seq = $urandom_range(0, 5);
    broken = ($urandom_range(0, 9) == 0);
    if (n_seq == 0) begin
      it = random_item(ACT_BASE);
      it.eseq = 1'b0;
      it.eset = 1'b1;
      send_item(it, 1'b0, '0);
      return;
    end
    for (int q = 0; q < n_seq; q++) begin
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 4);
      else len = aw + $urandom_range(0, 2) - 1;
      if (len < 1) len = 1;
      for (int k = 0; k < len; k++) begin
        // stray weight loads between characters
        if ($urandom_range(0, 19) == 0) send_item(random_item(ACT_LOAD), 1'b0, '0);
        last = (k == len - 1);
        it = random_item(ACT_BASE);
        it.eseq = last && !(broken && q == n_seq - 1);
        it.eset = last && (q == n_seq - 1);
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  initial begin
    scorer_item_t it;
    int           random_start;
    bit           overflow_done;
    int           phases;

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_valid            <= 1'b0;
    in_action           <= ACT_LOAD;
    in_column           <= '0;
    in_letter_slot      <= SLOT_A;
    in_weight           <= '0;
    in_base_char        <= '0;
    in_last_in_sequence <= 1'b0;
    in_last_in_set      <= 1'b0;
    row_typed           <= 1'b0;
    row_summary         <= '0;
    col_pos = 0;
    seq_score = 0;
    set_sum = 0;
    seqs_closed = 0;
    seqs_matched = 0;
    cut_q88 = 0;
    width_field = 6'd32;
    mode_field = MODE_COUNT;
    overflow_done = 1'b0;
    phases = 0;

    // directed rows: reset state, extremes of weights, registers and special cases
    directed_rows.push_back(typed_row("N", 1'b0, 1'b1, 0, 0, 1'b1));
    directed_rows.push_back(load_row(5'd0, SLOT_A, 16'sh7FFF, 1'b0));
    directed_rows.push_back(load_row(5'd0, SLOT_C, 16'sh8000, 1'b0));
    directed_rows.push_back(load_row(5'd0, SLOT_G, 16'sh0100, 1'b0));
    directed_rows.push_back(load_row(5'd0, SLOT_T, -16'sd1, 1'b0));
    // sequence and set flags on a load are ignored
    directed_rows.push_back(load_row(5'd1, SLOT_A, 16'sh0080, 1'b1));
    directed_rows.push_back(load_row(5'd31, SLOT_T, 16'sh1234, 1'b0));
    directed_rows.push_back(cfg_row(REG_WIDTH, 32'd1));
    directed_rows.push_back(char_row(CH_A_UP, 1'b1, 1'b0));
    directed_rows.push_back(char_row(CH_C_LO, 1'b1, 1'b0));
    directed_rows.push_back(char_row(8'hFF, 1'b0, 1'b0));
    directed_rows.push_back(typed_row(CH_G_LO, 1'b1, 1'b1, 2, 3, 1'b0));
    // set closed on an open sequence: nothing counted
    directed_rows.push_back(typed_row(CH_T_UP, 1'b0, 1'b1, 0, 0, 1'b1));
    directed_rows.push_back(cfg_row(REG_WIDTH, 32'd2));
    directed_rows.push_back(cfg_row(REG_CUTOFF, 32'h007F_FFFF));
    directed_rows.push_back(char_row(CH_A_UP, 1'b0, 1'b0));
    directed_rows.push_back(typed_row(CH_A_LO, 1'b1, 1'b1, 0, 1, 1'b0));
    directed_rows.push_back(cfg_row(REG_CUTOFF, 32'hFF80_0000));
    directed_rows.push_back(char_row(CH_C_UP, 1'b1, 1'b0));
    directed_rows.push_back(char_row(CH_C_UP, 1'b0, 1'b0));
    directed_rows.push_back(char_row(CH_A_UP, 1'b1, 1'b1));
    // mean of a negative odd total, width zero acting as one
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_MEAN)));
    directed_rows.push_back(cfg_row(REG_WIDTH, 32'd0));
    directed_rows.push_back(char_row(CH_C_LO, 1'b1, 1'b0));
    directed_rows.push_back(char_row(CH_T_LO, 1'b1, 1'b1));
    // width above the table acts as full width; a sequence with no bases
    directed_rows.push_back(cfg_row(REG_WIDTH, 32'd63));
    directed_rows.push_back(char_row(CH_G_UP, 1'b1, 1'b0));
    directed_rows.push_back(char_row("-", 1'b1, 1'b1));
    directed_rows.push_back(typed_row("N", 1'b0, 1'b1, 0, 0, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].summary);
      end
    end
    random_start = items_sent;

    // every table entry gets a weight before random sequences read it
    for (int c = 0; c < MAX_WIDTH_DEF; c++) begin
      for (int s = 0; s < 4; s++) begin
        it = random_item(ACT_LOAD);
        it.column = COLUMN_W'(c);
        it.slot = SLOT_W'(s);
        send_item(it, 1'b0, '0);
      end
    end

    // random phases, each under its own register setting
    while (items_sent - random_start < RANDOM_ITEMS || results_seen < MIN_RESULTS) begin
      settle();
      phases++;
      case ($urandom_range(0, 7))
        0:       write_reg(REG_CUTOFF, 32'hFF80_0000);
        1:       write_reg(REG_CUTOFF, 32'h007F_FFFF);
        default: write_reg(REG_CUTOFF, 32'($urandom_range(0, 120000)) - 32'd60000);
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_WIDTH, 32'd0);
        1:       write_reg(REG_WIDTH, 32'd63);
        2:       write_reg(REG_WIDTH, 32'd32);
        3:       write_reg(REG_WIDTH, 32'($urandom_range(0, 63)));
        default: write_reg(REG_WIDTH, 32'($urandom_range(1, 6)));
      endcase
      write_reg(REG_MODE, $urandom_range(0, 1) ? 32'(MODE_MEAN) : 32'(MODE_COUNT));
      if (!overflow_done && items_sent - random_start >= 250) begin
        // more sequences than the block keeps in one set
        write_reg(REG_WIDTH, 32'd1);
        for (int k = 0; k < OVERFLOW_SEQS; k++) begin
          it = random_item(ACT_BASE);
          it.eseq = 1'b1;
          it.eset = (k == OVERFLOW_SEQS - 1);
          send_item(it, 1'b0, '0);
        end
        overflow_done = 1'b1;
      end else begin
        repeat ($urandom_range(3, 8)) send_set();
      end
    end

    settle();
    $display("sent %0d beats (%0d directed) over %0d register phases, incl. an overflow set",
             items_sent, random_start, phases);
    $display("checked %0d set results, %0d failures", results_seen, failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
